// ===== src/ncsq_pkg.sv =====
package ncsq_pkg;

  // Field widths of the stream payloads
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned ERR_W      = 43;
  localparam int unsigned LVL_W      = 9;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  // Q1.14 unity and the saturation point of the Q15.28 error sum
  localparam logic signed [SMP_W-1:0] ONE_Q14   = 16'sd16384;
  localparam logic [LVL_W-1:0]        LVL_RESET = 9'd16;
  localparam logic [ERR_W:0]          ERR_MAX   = 44'h400_0000_0000;

  // Transaction kind carried on in_tuser
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUANT = 1'b1
  } func_t;

  typedef struct packed {
    logic cb_write;    // store centroid at entry_index
    logic start;       // capture sample, open the search window
    logic search;      // issue next search read (or first neighbor read)
    logic search_upd;  // narrow the window with the returned entry
    logic nbr_eval;    // compare the returned neighbor
    logic nbr_first;   // first neighbor seeds the best candidate
    logic sq_calc;     // square the winning distance
    logic finish;      // accumulate and load the output register
  } ncsq_cmd_t;

  typedef struct packed {
    logic more_search;
    logic nbr_more;
    logic out_free;
  } ncsq_sts_t;

endpackage

// ===== src/nearest_centroid_scalar_quantizer.sv =====
// Nearest-centroid scalar quantizer.
// Input stream (in_*): in_tuser selects the transaction kind. A write transaction
// stores centroid_value at entry_index of the codebook while staying idle; it makes
// no result. A quantize transaction clamps sample to [-1,1], binary-searches the
// ascending codebook for the first centroid not below it, picks the closest of that
// entry and its two neighbors (lower index wins a tie) and emits its index.
// The squared error of each sample is summed, saturating at 2^42; on the sample that
// carries in_tlast the sum goes out with out_tlast set and is cleared.
// Config port (cfg_*): cfg_ready is always high; the user must write level_count only
// while idle, which the block leaves unenforced.
// A quantize transaction occupies the block from acceptance until its result is
// loaded; no new transaction is accepted meanwhile. It makes k search steps, where
// k <= ceil(log2(level_count)), and m (1 to 3) neighbor reads, one read per cycle
// through the single codebook read port.
// Output: one result register. The next transaction is accepted while a result
// waits; a stalled receiver only holds the block in its last step until taken.
// Reset clears the error sum, sets level_count to 16 and empties the output; the
// codebook is not cleared and must be written before use.
module nearest_centroid_scalar_quantizer #(
  parameter int MAX_LEVELS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] entry_index, [23:8] centroid_value, [39:24] sample
  input  logic [ncsq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,   // last_of_vector
  // [0] func
  input  logic                              in_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ncsq_pkg::LVL_W-1:0]        cfg_data,   // level_count
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] code_index, [50:8] error_sum, [55:51] zero
  output logic [ncsq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast   // final_res
);
  import ncsq_pkg::*;

  ncsq_cmd_t cmd;
  ncsq_sts_t sts;

  // Config never stalls
  assign cfg_ready = 1'b1;

  ncsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  ncsq_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A quantize transaction blocks the input for at least the following cycle
  a_quant_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FUNC_QUANT)) |=> !in_tready)
    else $error("input accepted during a quantize transaction");

  // Only the last sample of a vector reports a nonzero error sum
  a_err_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[50:8] == '0))
    else $error("error sum reported on a non-final result");

  // The sum never passes the saturation point
  a_err_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[50:8]} <= ERR_MAX))
    else $error("error sum beyond saturation");

  // Emitted index lies inside the codebook
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({24'd0, out_tdata[7:0]} < 32'(MAX_LEVELS)))
    else $error("code index beyond codebook depth");

endmodule

// ===== src/ncsq_ctrl.sv =====
module ncsq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  ncsq_pkg::ncsq_sts_t sts,
  output ncsq_pkg::ncsq_cmd_t cmd
);
  import ncsq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SEARCH,
    ST_NBR_FIRST,
    ST_NBR,
    ST_SQUARE,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (func_t'(in_tuser) == FUNC_QUANT) begin
            cmd.start = 1'b1;
            state_nxt = ST_START;
          end else begin
            cmd.cb_write = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd.search = 1'b1;
        state_nxt  = sts.more_search ? ST_SEARCH : ST_NBR_FIRST;
      end
      ST_SEARCH: begin
        cmd.search     = 1'b1;
        cmd.search_upd = 1'b1;
        state_nxt      = sts.more_search ? ST_SEARCH : ST_NBR_FIRST;
      end
      ST_NBR_FIRST: begin
        cmd.nbr_eval  = 1'b1;
        cmd.nbr_first = 1'b1;
        state_nxt     = sts.nbr_more ? ST_NBR : ST_SQUARE;
      end
      ST_NBR: begin
        cmd.nbr_eval = 1'b1;
        state_nxt    = sts.nbr_more ? ST_NBR : ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.sq_calc = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/ncsq_dp.sv =====
module ncsq_dp #(
  parameter int MAX_LEVELS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ncsq_pkg::ncsq_cmd_t                  cmd,
  output ncsq_pkg::ncsq_sts_t                  sts,
  input  logic [ncsq_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 cfg_valid,
  input  logic [ncsq_pkg::LVL_W-1:0]           cfg_data,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [ncsq_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import ncsq_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEVELS);
  localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVELS);

  logic signed [SMP_W-1:0] cb_mem [MAX_LEVELS];
  logic signed [SMP_W-1:0] rdata_r;
  logic [IDX_W-1:0]        rd_addr;

  logic [LVL_W-1:0]        lvl_r;
  logic signed [SMP_W-1:0] smp_r;
  logic                    last_r;
  logic [IDX_W-1:0]        lo_r, hi_r, mid_r, j_r, jhi_r, best_r;
  logic [SMP_W-1:0]        bestd_r;
  logic [SQ_W-1:0]         sq_r;
  logic [ERR_W-1:0]        acc_r;
  logic                    out_valid_r;
  logic [CODE_W-1:0]       code_r;
  logic [ERR_W-1:0]        err_r;
  logic                    fin_r;

  logic [CODE_W-1:0]       wr_idx;
  logic signed [SMP_W-1:0] wr_val, smp_in, smp_clamp;
  logic                    wr_en;
  logic [LVL_W-1:0]        nm1_full;
  logic [IDX_W-1:0]        nm1;
  logic [IDX_W-1:0]        lo_cur, hi_cur, mid_cur, jlo_cur, jhi_cur, j_inc;
  logic [IDX_W:0]          mid_sum;
  logic signed [SMP_W:0]   diff;
  logic [SMP_W:0]          diff_abs;
  logic [SMP_W-1:0]        d_cur;
  logic [ERR_W:0]          sum;
  logic [ERR_W-1:0]        acc_sat;

  assign wr_idx = in_tdata[7:0];
  assign wr_val = $signed(in_tdata[23:8]);
  assign smp_in = $signed(in_tdata[39:24]);
  assign wr_en  = cmd.cb_write && ({1'b0, wr_idx} < MAX_LVL);

  // Clamp the sample to plus or minus one
  always_comb begin
    if (smp_in > ONE_Q14) begin
      smp_clamp = ONE_Q14;
    end else if (smp_in < -ONE_Q14) begin
      smp_clamp = -ONE_Q14;
    end else begin
      smp_clamp = smp_in;
    end
  end

  // Highest index in use: level count 0 acts as 1, above the depth as the depth
  always_comb begin
    if (lvl_r == '0) begin
      nm1_full = '0;
    end else if (lvl_r > MAX_LVL) begin
      nm1_full = MAX_LVL - 1'b1;
    end else begin
      nm1_full = lvl_r - 1'b1;
    end
  end
  assign nm1 = nm1_full[IDX_W-1:0];

  always_comb begin
    lo_cur = lo_r;
    hi_cur = hi_r;
    if (cmd.search_upd) begin
      if (rdata_r < smp_r) begin
        lo_cur = mid_r + 1'b1;
      end else begin
        hi_cur = mid_r;
      end
    end
    mid_sum = {1'b0, lo_cur} + {1'b0, hi_cur};
    mid_cur = mid_sum[IDX_W:1];
    jlo_cur = (lo_cur == '0) ? '0 : lo_cur - 1'b1;
    jhi_cur = (lo_cur < nm1) ? lo_cur + 1'b1 : nm1;
    j_inc   = j_r + 1'b1;
  end

  assign sts.more_search = (lo_cur < hi_cur);
  assign sts.nbr_more    = (j_r < jhi_r);
  assign sts.out_free    = !out_valid_r || out_tready;

  always_comb begin
    if (cmd.search) begin
      rd_addr = sts.more_search ? mid_cur : jlo_cur;
    end else begin
      rd_addr = j_inc;
    end
  end

  assign diff     = {smp_r[SMP_W-1], smp_r} - {rdata_r[SMP_W-1], rdata_r};
  assign diff_abs = diff[SMP_W] ? -diff : diff;
  assign d_cur    = diff_abs[SMP_W-1:0];

  // Saturating accumulate: acc + sq at or above the limit pins to the limit
  assign sum     = {1'b0, acc_r} + {{(ERR_W + 1 - SQ_W){1'b0}}, sq_r};
  assign acc_sat = (sum >= ERR_MAX) ? ERR_MAX[ERR_W-1:0] : sum[ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cb_mem[wr_idx[IDX_W-1:0]] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= cb_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      smp_r  <= smp_clamp;
      last_r <= in_tlast;
      lo_r   <= '0;
      hi_r   <= nm1;
    end
    if (cmd.search) begin
      lo_r  <= lo_cur;
      hi_r  <= hi_cur;
      mid_r <= mid_cur;
      j_r   <= jlo_cur;
      jhi_r <= jhi_cur;
    end
    if (cmd.nbr_eval) begin
      if (cmd.nbr_first || (d_cur < bestd_r)) begin
        best_r  <= j_r;
        bestd_r <= d_cur;
      end
      if (sts.nbr_more) begin
        j_r <= j_inc;
      end
    end
    if (cmd.sq_calc) begin
      sq_r <= SQ_W'(bestd_r) * SQ_W'(bestd_r);
    end
    if (cmd.finish) begin
      code_r <= CODE_W'(best_r);
      err_r  <= last_r ? acc_sat : '0;
      fin_r  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= LVL_RESET;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lvl_r <= cfg_data;
      end
      if (cmd.finish) begin
        acc_r       <= last_r ? '0 : acc_sat;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ERR_W - CODE_W){1'b0}}, err_r, code_r};
  assign out_tlast  = fin_r;

endmodule
